FILE: src/sfsl_pkg.sv
// Shared types and constants for the sorted free-space list.
// Used by sfsl_ctrl, sfsl_dpath and sorted_free_space_list.
package sfsl_pkg;

    // request codes (REQ_UNUSED is ignored and gives no result)
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [31:0] HEADER_POS = 32'd1;
    localparam logic [31:0] LINK_SKIP  = 32'd5;

    // controller -> datapath
    typedef struct packed {
        logic insert;      // place the incoming slot in order
        logic clear;       // empty the table
        logic plain;       // load a single non-entry result beat
        logic dump_init;   // reset link position and dump index
        logic dump_step;   // emit head entry and rotate the live entries
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic cnt_zero;    // table empty
        logic dump_last;   // head entry is the final one of the dump
    } sts_t;

endpackage

FILE: src/sfsl_ctrl.sv
// Controller FSM for the sorted free-space list.
// Depends on sfsl_pkg for cmd_t, sts_t and request codes.
module sfsl_ctrl
    import sfsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    case (req_type)
                        REQ_INSERT:
                        begin
                            cmd.insert = 1'b1;
                            cmd.plain  = 1'b1;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                            cmd.plain = 1'b1;
                        end
                        REQ_DUMP:
                        begin
                            if (sts.cnt_zero)
                            begin
                                cmd.plain = 1'b1;
                            end
                            else
                            begin
                                cmd.dump_init = 1'b1;
                                state_next    = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused code: beat dropped, no result
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.dump_step = 1'b1;
                    if (sts.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/sfsl_dpath.sv
// Datapath: ordered slot cells with parallel compare/shift, entry count,
// dump chain registers and the output register. Depends on sfsl_pkg.
module sfsl_dpath
    import sfsl_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] slot_size,
    input  logic [31:0] slot_offset,
    input  cmd_t        cmd,
    input  logic        out_ready,
    output sts_t        sts,
    output logic        out_valid,
    output logic [31:0] write_position,
    output logic [31:0] write_value,
    output logic [15:0] entry_size,
    output logic        entry_valid,
    output logic        last,
    output logic        status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [15:0]   size_reg [DEPTH];
    logic [15:0]   size_next[DEPTH];
    logic [31:0]   off_reg  [DEPTH];
    logic [31:0]   off_next [DEPTH];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] idx_reg;
    logic [31:0]   pos_reg;
    logic          full;
    logic          dump_last;
    logic [DEPTH-1:0] ge;

    logic          out_valid_reg;
    logic [31:0]   wpos_reg;
    logic [31:0]   wval_reg;
    logic [15:0]   esize_reg;
    logic          evalid_reg;
    logic          last_reg;
    logic          status_reg;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign cnt_m1    = cnt_reg - CW'(1);
    assign dump_last = (idx_reg == cnt_m1[IW-1:0]);

    // live entries not smaller than the new one; a prefix, as the table is sorted
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (CW'(i) < cnt_reg) && (slot_size <= size_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            size_next[i] = size_reg[i];
            off_next[i]  = off_reg[i];
        end
        if (cmd.insert && !full)
        begin
            if (!ge[0])
            begin
                size_next[0] = slot_size;
                off_next[0]  = slot_offset;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!ge[i])
                begin
                    if (ge[i-1])
                    begin
                        size_next[i] = slot_size;
                        off_next[i]  = slot_offset;
                    end
                    else
                    begin
                        size_next[i] = size_reg[i-1];
                        off_next[i]  = off_reg[i-1];
                    end
                end
            end
        end
        else if (cmd.dump_step)
        begin
            // rotate live entries one place towards the head; restored after a full dump
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                size_next[i] = size_reg[i+1];
                off_next[i]  = off_reg[i+1];
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (CW'(i) == cnt_m1)
                begin
                    size_next[i] = size_reg[0];
                    off_next[i]  = off_reg[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        off_reg  <= off_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.insert && !full)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dump_init)
        begin
            idx_reg <= '0;
            pos_reg <= HEADER_POS;
        end
        else if (cmd.dump_step)
        begin
            idx_reg <= idx_reg + IW'(1);
            pos_reg <= off_reg[0] + LINK_SKIP;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.plain || cmd.dump_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.plain)
        begin
            wpos_reg   <= '0;
            wval_reg   <= '0;
            esize_reg  <= '0;
            evalid_reg <= 1'b0;
            last_reg   <= 1'b1;
            status_reg <= cmd.insert && full;
        end
        else if (cmd.dump_step)
        begin
            wpos_reg   <= pos_reg;
            wval_reg   <= off_reg[0];
            esize_reg  <= size_reg[0];
            evalid_reg <= 1'b1;
            last_reg   <= dump_last;
            status_reg <= 1'b0;
        end
    end

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.dump_last = dump_last;

    assign out_valid      = out_valid_reg;
    assign write_position = wpos_reg;
    assign write_value    = wval_reg;
    assign entry_size     = esize_reg;
    assign entry_valid    = evalid_reg;
    assign last           = last_reg;
    assign status         = status_reg;

endmodule

FILE: src/sorted_free_space_list.sv
// Sorted free-space list: freed slots kept largest first, dumped as a link chain.
// Insert, clear and dump of an empty table: one result beat, the cycle after accept;
// one such request per cycle while the output is drained (single compare/shift step).
// Dump of N entries: N beats, the first after S_DUMP is entered, then one per cycle
// while drained, paced by the rotating table's head cell; input held off until done.
// Reset clears the entry count and the FSM; slot contents are undefined until written.
module sorted_free_space_list
    import sfsl_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] slot_size,
    input  logic [31:0] slot_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] write_position,
    output logic [31:0] write_value,
    output logic [15:0] entry_size,
    output logic        entry_valid,
    output logic        last,
    output logic        status
);

    cmd_t cmd;
    sts_t sts;

    sfsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfsl_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .slot_size      (slot_size),
        .slot_offset    (slot_offset),
        .cmd            (cmd),
        .out_ready      (out_ready),
        .sts            (sts),
        .out_valid      (out_valid),
        .write_position (write_position),
        .write_value    (write_value),
        .entry_size     (entry_size),
        .entry_valid    (entry_valid),
        .last           (last),
        .status         (status)
    );

endmodule
